>>> rtl/wsd_pkg.sv
// Package for the WAV stream decoder: phase codes, result kinds, encodings,
// error codes and the G.711 expansion functions. No dependencies.
package wsd_pkg;

    localparam int MaxFormatBytes = 20;

    localparam logic [31:0] TAG_RIFF = 32'h52494646;
    localparam logic [31:0] TAG_WAVE = 32'h57415645;
    localparam logic [31:0] TAG_FMT  = 32'h666D7420;
    localparam logic [31:0] TAG_DATA = 32'h64617461;

    localparam logic [15:0] FMT_PCM  = 16'h0001;
    localparam logic [15:0] FMT_ALAW = 16'h0006;
    localparam logic [15:0] FMT_ULAW = 16'h0007;

    typedef enum logic [2:0] {
        PH_HEAD, PH_FMT_HDR, PH_FMT_SKIP, PH_FMT_BODY,
        PH_DATA_HDR, PH_DATA_SKIP, PH_DATA, PH_IDLE
    } phase_t;

    typedef enum logic [1:0] {
        KIND_SAMPLE = 2'd0, KIND_ACCEPT = 2'd1, KIND_REJECT = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        ENC_PCM16 = 2'd0, ENC_PCM8 = 2'd1, ENC_ULAW = 2'd2, ENC_ALAW = 2'd3
    } enc_t;

    localparam logic [2:0] ERR_NOT_WAVE = 3'd0;
    localparam logic [2:0] ERR_NO_FMT   = 3'd1;
    localparam logic [2:0] ERR_FMT_SIZE = 3'd2;
    localparam logic [2:0] ERR_UNSUPP   = 3'd3;
    localparam logic [2:0] ERR_NO_DATA  = 3'd4;

    // Classified item passed from the parser to the sample unit.
    typedef struct packed {
        kind_t       kind;
        logic        pcm_byte;     // sample unit builds the value from code_byte
        enc_t        enc;
        logic [7:0]  code_byte;
        logic [15:0] value;        // ready-made PCM16 sample
        logic        last;
        logic [15:0] channels;
        logic [31:0] rate;
        logic [2:0]  err;
    } item_t;

    function automatic logic [15:0] ulaw_expand(input logic [7:0] b);
        logic [7:0]  u;
        logic [15:0] t;
        begin
            u = ~b;
            t = ({12'd0, u[3:0]} << 3) + 16'h0084;
            t = t << u[6:4];
            ulaw_expand = u[7] ? (16'h0084 - t) : (t - 16'h0084);
        end
    endfunction

    function automatic logic [15:0] alaw_expand(input logic [7:0] b);
        logic [7:0]  a;
        logic [15:0] t;
        begin
            a = b ^ 8'h55;
            t = {8'd0, a[3:0], 4'd0};
            if (a[6:4] == 3'd0)
                t = t + 16'd8;
            else if (a[6:4] == 3'd1)
                t = t + 16'h0108;
            else
                t = (t + 16'h0108) << (a[6:4] - 3'd1);
            alaw_expand = a[7] ? t : (16'd0 - t);
        end
    endfunction

endpackage

>>> rtl/wsd_parser.sv
// Front part of the WAV stream decoder: parses the RIFF header byte by byte
// and classifies each byte into at most one item. Depends on wsd_pkg.
module wsd_parser (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    input  logic [7:0]     file_byte,
    input  logic           first_of_file,
    input  logic           end_of_file,
    output logic           item_valid,
    output wsd_pkg::item_t item
);
    import wsd_pkg::*;

    phase_t      phase_reg, phase_next;
    logic [4:0]  bif_reg, bif_next;
    logic [31:0] tag_reg, tag_next;
    logic [31:0] clen_reg, clen_next;
    logic [31:0] skip_reg, skip_next;
    logic [15:0] ftag_reg, ftag_next;
    logic [15:0] chan_reg, chan_next;
    logic [31:0] rate_reg, rate_next;
    logic [15:0] bits_reg, bits_next;
    logic [31:0] dleft_reg, dleft_next;
    logic [8:0]  hold_reg, hold_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_HEAD;
            bif_reg   <= '0;
            tag_reg   <= '0;
            clen_reg  <= '0;
            skip_reg  <= '0;
            ftag_reg  <= '0;
            chan_reg  <= '0;
            rate_reg  <= '0;
            bits_reg  <= '0;
            dleft_reg <= '0;
            hold_reg  <= '0;
        end
        else if (in_valid)
        begin
            phase_reg <= phase_next;
            bif_reg   <= bif_next;
            tag_reg   <= tag_next;
            clen_reg  <= clen_next;
            skip_reg  <= skip_next;
            ftag_reg  <= ftag_next;
            chan_reg  <= chan_next;
            rate_reg  <= rate_next;
            bits_reg  <= bits_next;
            dleft_reg <= dleft_next;
            hold_reg  <= hold_next;
        end
    end

    always_comb
    begin
        phase_t      ph;
        logic [4:0]  bif;
        logic [31:0] tag, clen, skip, rate, dleft;
        logic [15:0] ftag, chan, bits;
        logic [8:0]  hold;
        logic        got, supp, hit;
        enc_t        enc;
        logic [2:0]  k;

        ph = phase_reg; bif = bif_reg; tag = tag_reg; clen = clen_reg;
        skip = skip_reg; ftag = ftag_reg; chan = chan_reg; rate = rate_reg;
        bits = bits_reg; dleft = dleft_reg; hold = hold_reg;
        if (first_of_file)
        begin
            ph = PH_HEAD; bif = '0; tag = '0; clen = '0; skip = '0; ftag = '0;
            chan = '0; rate = '0; bits = '0; dleft = '0; hold = '0;
        end
        got  = 1'b0;
        item = '0;
        hit  = 1'b0;
        k    = '0;

        if (ftag == FMT_ULAW)      enc = ENC_ULAW;
        else if (ftag == FMT_ALAW) enc = ENC_ALAW;
        else if (bits == 16'd8)    enc = ENC_PCM8;
        else                       enc = ENC_PCM16;

        unique case (ph)
            PH_HEAD:
            begin
                tag = {tag[23:0], file_byte};
                if ((bif == 5'd3 && tag != TAG_RIFF) || (bif == 5'd11 && tag != TAG_WAVE))
                begin
                    got = 1'b1; item.kind = KIND_REJECT; item.err = ERR_NOT_WAVE;
                    ph = PH_IDLE;
                end
                else if (bif == 5'd11)
                begin
                    ph = PH_FMT_HDR; bif = '0;
                end
                else
                    bif = bif + 5'd1;
            end
            PH_FMT_HDR, PH_DATA_HDR:
            begin
                if (bif < 5'd4)
                begin
                    tag = {tag[23:0], file_byte};
                    if (bif == 5'd0) clen = '0;
                end
                else
                begin
                    unique case (bif[1:0])
                        2'd0: clen[7:0]   = clen[7:0]   | file_byte;
                        2'd1: clen[15:8]  = clen[15:8]  | file_byte;
                        2'd2: clen[23:16] = clen[23:16] | file_byte;
                        default: clen[31:24] = clen[31:24] | file_byte;
                    endcase
                end
                if (bif >= 5'd7)
                begin
                    bif = '0;
                    hit = (ph == PH_FMT_HDR) ? (tag == TAG_FMT) : (tag == TAG_DATA);
                    if (!hit)
                    begin
                        // skip the chunk plus its pad byte
                        skip = clen;
                        bif  = {4'd0, clen[0]};
                        if (clen != 0 || clen[0])
                            ph = (ph == PH_FMT_HDR) ? PH_FMT_SKIP : PH_DATA_SKIP;
                    end
                    else if (clen == 0)
                    begin
                        got = 1'b1; item.kind = KIND_REJECT;
                        item.err = (ph == PH_FMT_HDR) ? ERR_NO_FMT : ERR_NO_DATA;
                        ph = PH_IDLE;
                    end
                    else if (ph == PH_FMT_HDR)
                    begin
                        if (clen > 32'(MaxFormatBytes))
                        begin
                            got = 1'b1; item.kind = KIND_REJECT; item.err = ERR_FMT_SIZE;
                            ph = PH_IDLE;
                        end
                        else
                        begin
                            ftag = '0; chan = '0; rate = '0; bits = '0;
                            skip = clen; ph = PH_FMT_BODY;
                        end
                    end
                    else
                    begin
                        dleft = clen; hold = '0; ph = PH_DATA;
                        got = 1'b1; item.kind = KIND_ACCEPT; item.enc = enc;
                        item.channels = chan; item.rate = rate;
                    end
                end
                else
                    bif = bif + 5'd1;
            end
            PH_FMT_SKIP, PH_DATA_SKIP:
            begin
                if (skip != 0) skip = skip - 32'd1;
                else bif = '0;
                if (skip == 0 && bif == 0)
                    ph = (ph == PH_FMT_SKIP) ? PH_FMT_HDR : PH_DATA_HDR;
            end
            PH_FMT_BODY:
            begin
                case (bif)
                    5'd0:  ftag[7:0]   = file_byte;
                    5'd1:  ftag[15:8]  = file_byte;
                    5'd2:  chan[7:0]   = file_byte;
                    5'd3:  chan[15:8]  = file_byte;
                    5'd4:  rate[7:0]   = file_byte;
                    5'd5:  rate[15:8]  = file_byte;
                    5'd6:  rate[23:16] = file_byte;
                    5'd7:  rate[31:24] = file_byte;
                    5'd14: bits[7:0]   = file_byte;
                    5'd15: bits[15:8]  = file_byte;
                    default: ;
                endcase
                bif = bif + 5'd1;
                if (skip != 0) skip = skip - 32'd1;
                if (skip == 0)
                begin
                    supp = (ftag == FMT_ULAW) || (ftag == FMT_ALAW) ||
                           (ftag == FMT_PCM && (bits == 16'd8 || bits == 16'd16));
                    if (!supp)
                    begin
                        got = 1'b1; item.kind = KIND_REJECT; item.err = ERR_UNSUPP;
                        ph = PH_IDLE;
                    end
                    else if (clen[0])
                    begin
                        ph = PH_DATA_SKIP; bif = 5'd1;
                    end
                    else
                    begin
                        ph = PH_DATA_HDR; bif = '0;
                    end
                end
            end
            PH_DATA:
            begin
                if (dleft != 0) dleft = dleft - 32'd1;
                item.kind = KIND_SAMPLE;
                item.enc  = enc;
                item.code_byte = file_byte;
                if (enc == ENC_PCM16)
                begin
                    if (hold[8])
                    begin
                        got = 1'b1;
                        item.value = {file_byte, hold[7:0]};
                        item.last = dleft < 32'd2;
                        hold = '0;
                    end
                    else
                    begin
                        hold = {1'b1, file_byte};
                        if (dleft == 0) ph = PH_IDLE;
                    end
                end
                else
                begin
                    got = 1'b1;
                    item.pcm_byte = 1'b1;
                    item.last = dleft == 0;
                end
                if (got && item.last) ph = PH_IDLE;
            end
            default: ;
        endcase

        if (end_of_file)
        begin
            if (!got)
            begin
                got = 1'b1;
                case (ph)
                    PH_HEAD:                   k = ERR_NOT_WAVE;
                    PH_FMT_HDR, PH_FMT_SKIP:   k = ERR_NO_FMT;
                    PH_FMT_BODY:               k = ERR_FMT_SIZE;
                    PH_DATA_HDR, PH_DATA_SKIP: k = ERR_NO_DATA;
                    default:                   got = 1'b0;
                endcase
                if (got)
                begin
                    item = '0; item.kind = KIND_REJECT; item.err = k;
                end
            end
            ph = PH_IDLE;
        end

        item_valid = in_valid && got;
        phase_next = ph; bif_next = bif; tag_next = tag; clen_next = clen;
        skip_next = skip; ftag_next = ftag; chan_next = chan; rate_next = rate;
        bits_next = bits; dleft_next = dleft; hold_next = hold;
    end
endmodule

>>> rtl/wsd_fifo.sv
// Short queue between parser and sample unit; two entries with full/empty.
// Depends on wsd_pkg.
module wsd_fifo (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           wr_en,
    input  wsd_pkg::item_t wr_item,
    output logic           full,
    input  logic           rd_en,
    output logic           empty,
    output wsd_pkg::item_t rd_item
);
    import wsd_pkg::*;

    item_t      mem_reg [2];
    logic       wp_reg, rp_reg;
    logic [1:0] cnt_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en) mem_reg[wp_reg] <= wr_item;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg <= 1'b0; rp_reg <= 1'b0; cnt_reg <= '0;
        end
        else
        begin
            if (wr_en) wp_reg <= ~wp_reg;
            if (rd_en) rp_reg <= ~rp_reg;
            cnt_reg <= cnt_reg + {1'b0, wr_en} - {1'b0, rd_en};
        end
    end

    assign full    = cnt_reg == 2'd2;
    assign empty   = cnt_reg == 2'd0;
    assign rd_item = mem_reg[rp_reg];
endmodule

>>> rtl/wsd_sample_unit.sv
// Back part: expands queued items into result fields and holds them in an
// output register stage. Depends on wsd_pkg.
module wsd_sample_unit (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           q_empty,
    input  wsd_pkg::item_t q_item,
    output logic           q_pop,
    output logic           empty,
    input  logic           pop,
    output logic [1:0]     result_kind,
    output logic [15:0]    sample_value,
    output logic           last_sample,
    output logic [1:0]     encoding,
    output logic [15:0]    channel_count,
    output logic [31:0]    rate_hz,
    output logic [2:0]     error_code
);
    import wsd_pkg::*;

    logic        full_reg;
    logic [1:0]  kind_reg;
    logic [15:0] val_reg;
    logic        last_reg;
    logic [1:0]  enc_reg;
    logic [15:0] chan_reg;
    logic [31:0] rate_reg;
    logic [2:0]  err_reg;
    logic [15:0] val;

    assign q_pop = !q_empty && (!full_reg || pop);

    always_comb
    begin
        val = q_item.value;
        if (q_item.pcm_byte)
        begin
            unique case (q_item.enc)
                ENC_ULAW: val = ulaw_expand(q_item.code_byte);
                ENC_ALAW: val = alaw_expand(q_item.code_byte);
                default:  val = {q_item.code_byte, 8'd0} - 16'd32767;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            full_reg <= 1'b0;
        else if (q_pop)
            full_reg <= 1'b1;
        else if (pop)
            full_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            kind_reg <= q_item.kind;
            val_reg  <= val;
            last_reg <= q_item.last;
            enc_reg  <= q_item.kind == KIND_ACCEPT ? q_item.enc : ENC_PCM16;
            chan_reg <= q_item.channels;
            rate_reg <= q_item.rate;
            err_reg  <= q_item.err;
        end
    end

    assign empty         = !full_reg;
    assign result_kind   = kind_reg;
    assign sample_value  = val_reg;
    assign last_sample   = last_reg;
    assign encoding      = enc_reg;
    assign channel_count = chan_reg;
    assign rate_hz       = rate_reg;
    assign error_code    = err_reg;
endmodule

>>> rtl/wav_stream_decoder.sv
// Top level of the WAV stream decoder. Uses wsd_pkg, wsd_parser, wsd_fifo
// and wsd_sample_unit.
//
// Feed a WAV file one byte per transfer, marking the first byte with
// first_of_file and the last with end_of_file. The parser accepts one byte
// every cycle while full is low; each byte yields at most one result: a
// header report (kind 1, with encoding, channels and rate), a rejection
// (kind 2, with an error code), or a decoded 16-bit sample (kind 0,
// last_sample on the final one). Results pass through a two-entry queue
// and then an output register; a stalled consumer blocks input only once
// both fill, and full rises when the queue is full. Sustained rate is one
// byte per cycle while the consumer keeps popping.
module wav_stream_decoder (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  file_byte,
    input  logic        first_of_file,
    input  logic        end_of_file,
    output logic        empty,
    input  logic        pop,
    output logic [1:0]  result_kind,
    output logic signed [15:0] sample_value,
    output logic        last_sample,
    output logic [1:0]  encoding,
    output logic [15:0] channel_count,
    output logic [31:0] rate_hz,
    output logic [2:0]  error_code
);
    import wsd_pkg::*;

    logic  accept, item_valid, q_empty, q_pop;
    item_t item, q_item;
    logic [15:0] sval;

    // Accept a byte only when the queue has room for its result.
    assign accept = push && !full;

    wsd_parser u_parser (
        .clk(clk), .rst_n(rst_n), .in_valid(accept), .file_byte(file_byte),
        .first_of_file(first_of_file), .end_of_file(end_of_file),
        .item_valid(item_valid), .item(item)
    );

    wsd_fifo u_fifo (
        .clk(clk), .rst_n(rst_n), .wr_en(item_valid), .wr_item(item),
        .full(full), .rd_en(q_pop), .empty(q_empty), .rd_item(q_item)
    );

    wsd_sample_unit u_back (
        .clk(clk), .rst_n(rst_n), .q_empty(q_empty), .q_item(q_item),
        .q_pop(q_pop), .empty(empty), .pop(pop), .result_kind(result_kind),
        .sample_value(sval), .last_sample(last_sample), .encoding(encoding),
        .channel_count(channel_count), .rate_hz(rate_hz),
        .error_code(error_code)
    );

    assign sample_value = signed'(sval);
endmodule
